FILE: sv/mcp_pkg.sv
// package for the mqtt connect payload parser
// section codes, status codes, shared structs and next-section function; no dependencies
package mcp_pkg;

    // section tags
    localparam logic [3:0] SEC_NAME_LEN   = 4'd0;
    localparam logic [3:0] SEC_NAME       = 4'd1;
    localparam logic [3:0] SEC_LEVEL      = 4'd2;
    localparam logic [3:0] SEC_FLAGS      = 4'd3;
    localparam logic [3:0] SEC_KEEPALIVE  = 4'd4;
    localparam logic [3:0] SEC_ID_LEN     = 4'd5;
    localparam logic [3:0] SEC_ID         = 4'd6;
    localparam logic [3:0] SEC_WTOPIC_LEN = 4'd7;
    localparam logic [3:0] SEC_WTOPIC     = 4'd8;
    localparam logic [3:0] SEC_WMSG_LEN   = 4'd9;
    localparam logic [3:0] SEC_WMSG       = 4'd10;
    localparam logic [3:0] SEC_USER_LEN   = 4'd11;
    localparam logic [3:0] SEC_USER       = 4'd12;
    localparam logic [3:0] SEC_PW_LEN     = 4'd13;
    localparam logic [3:0] SEC_PW         = 4'd14;
    localparam logic [3:0] SEC_TRAILING   = 4'd15;

    // status codes
    localparam logic [4:0] ST_BUSY       = 5'd0;
    localparam logic [4:0] ST_DONE       = 5'd1;
    localparam logic [4:0] ST_TRUNC_BASE = 5'd2;

    // connect flag bit positions
    localparam int FLAG_USER    = 7;
    localparam int FLAG_PW      = 6;
    localparam int FLAG_RETAIN  = 5;
    localparam int FLAG_QOS_HI  = 4;
    localparam int FLAG_QOS_LO  = 3;
    localparam int FLAG_WILL    = 2;
    localparam int FLAG_CLEAN   = 1;

    // one result transaction as carried through the queue
    typedef struct packed {
        logic [3:0]  section;
        logic [7:0]  byte_out;
        logic        is_content;
        logic [7:0]  flags;
        logic [15:0] alive_secs;
        logic [7:0]  proto_rev;
        logic [4:0]  status;
    } t_result;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

    // front parser state visible to the top level
    typedef struct packed {
        logic [3:0] section;
        logic       high_seen;
    } t_front_stat;

    // section entered once the string that starts at a length section ends
    function automatic logic [3:0] after_string(input logic [3:0] len_sec,
                                                input logic [7:0] flags);
        logic will_f;
        logic user_f;
        logic pw_f;
        logic [3:0] pw_next;
        logic [3:0] user_next;
        will_f    = flags[FLAG_WILL];
        user_f    = flags[FLAG_USER];
        pw_f      = flags[FLAG_PW];
        pw_next   = pw_f ? SEC_PW_LEN : SEC_TRAILING;
        user_next = user_f ? SEC_USER_LEN : pw_next;
        case (len_sec)
            SEC_NAME_LEN:   after_string = SEC_LEVEL;
            SEC_ID_LEN:     after_string = will_f ? SEC_WTOPIC_LEN : user_next;
            SEC_WTOPIC_LEN: after_string = SEC_WMSG_LEN;
            SEC_WMSG_LEN:   after_string = user_next;
            SEC_USER_LEN:   after_string = pw_next;
            default:        after_string = SEC_TRAILING;
        endcase
    endfunction

endpackage

FILE: sv/mcp_front.sv
// front part: accepts bytes, walks the connect sections, builds result transactions
// depends on mcp_pkg
module mcp_front import mcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output t_result     o_result,
    output t_front_stat o_stat
);

    logic [3:0]  r_section, n_section;
    logic        r_high_seen, n_high_seen;
    logic [7:0]  r_length_high, n_length_high;
    logic [15:0] r_remaining, n_remaining;
    logic [7:0]  r_flags, n_flags;
    logic [15:0] r_alive_secs, n_alive_secs;
    logic [7:0]  r_level, n_level;
    logic [15:0] w_len;
    logic        w_is_content;

    assign w_len = {r_length_high, i_data_byte};

    // section walk for one byte
    always_comb begin
        n_section     = r_section;
        n_high_seen   = r_high_seen;
        n_length_high = r_length_high;
        n_remaining   = r_remaining;
        n_flags       = r_flags;
        n_alive_secs  = r_alive_secs;
        n_level       = r_level;
        w_is_content  = 1'b0;
        unique case (r_section) inside
            SEC_NAME_LEN, SEC_ID_LEN, SEC_WTOPIC_LEN, SEC_WMSG_LEN, SEC_USER_LEN,
            SEC_PW_LEN: begin
                if (!r_high_seen) begin
                    n_high_seen   = 1'b1;
                    n_length_high = i_data_byte;
                end else begin
                    n_high_seen = 1'b0;
                    if (w_len == 16'd0) begin
                        n_section = after_string(r_section, r_flags);
                    end else begin
                        n_remaining = w_len;
                        n_section   = r_section + 4'd1;
                    end
                end
            end
            SEC_NAME, SEC_ID, SEC_WTOPIC, SEC_WMSG, SEC_USER, SEC_PW: begin
                w_is_content = 1'b1;
                if (r_remaining <= 16'd1) begin
                    n_remaining = 16'd0;
                    n_section   = after_string(r_section - 4'd1, r_flags);
                end else begin
                    n_remaining = r_remaining - 16'd1;
                end
            end
            SEC_LEVEL: begin
                n_level   = i_data_byte;
                n_section = SEC_FLAGS;
            end
            SEC_FLAGS: begin
                n_flags   = i_data_byte;
                n_section = SEC_KEEPALIVE;
            end
            SEC_KEEPALIVE: begin
                if (!r_high_seen) begin
                    n_high_seen   = 1'b1;
                    n_length_high = i_data_byte;
                end else begin
                    n_high_seen  = 1'b0;
                    n_alive_secs = w_len;
                    n_section    = SEC_ID_LEN;
                end
            end
            default: begin
                // trailing bytes change nothing
            end
        endcase
    end

    // result transaction, held fields after this byte
    always_comb begin
        o_result.section    = r_section;
        o_result.byte_out   = i_data_byte;
        o_result.is_content = w_is_content;
        o_result.flags      = n_flags;
        o_result.alive_secs = n_alive_secs;
        o_result.proto_rev  = n_level;
        if (!i_last_byte) begin
            o_result.status = ST_BUSY;
        end else if (n_section == SEC_TRAILING) begin
            o_result.status = ST_DONE;
        end else begin
            o_result.status = ST_TRUNC_BASE + {1'b0, n_section};
        end
    end

    // parser state, cleared at the end of each packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last_byte)) begin
            r_section     <= SEC_NAME_LEN;
            r_high_seen   <= 1'b0;
            r_length_high <= 8'd0;
            r_remaining   <= 16'd0;
            r_flags       <= 8'd0;
            r_alive_secs  <= 16'd0;
            r_level       <= 8'd0;
        end else if (i_fire) begin
            r_section     <= n_section;
            r_high_seen   <= n_high_seen;
            r_length_high <= n_length_high;
            r_remaining   <= n_remaining;
            r_flags       <= n_flags;
            r_alive_secs  <= n_alive_secs;
            r_level       <= n_level;
        end
    end

    assign o_stat.section   = r_section;
    assign o_stat.high_seen = r_high_seen;

endmodule

FILE: sv/mcp_queue.sv
// two-entry queue of result transactions between front and back
// depends on mcp_pkg
module mcp_queue import mcp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_pop,
    output t_result o_data,
    output t_q_stat o_stat
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data           = r_mem[r_rd_ptr];
    assign o_stat.full      = (r_count == 2'd2);
    assign o_stat.not_empty = (r_count != 2'd0);

endmodule

FILE: sv/mcp_back.sv
// back part: output register that presents result transactions downstream
// depends on mcp_pkg
module mcp_back import mcp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_data,
    input  t_q_stat i_q_stat,
    output logic    o_pop,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // load when the register is empty or being taken
    assign o_pop = i_q_stat.not_empty && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_q_stat.not_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_data;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: sv/mqtt_connect_payload_parser.sv
// top level of the mqtt connect payload parser
// depends on mcp_pkg, mcp_front, mcp_queue, mcp_back
//
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+------------------------------------------
// input    | in        | i_valid / o_stall  | i_data_byte, i_last_byte
// result   | out       | o_valid / i_stall  | o_section .. o_status (one per input byte)
//
// one byte accepted per cycle while o_stall is low; the front's section state machine
// updates in that cycle; its result goes through the queue, then the output register.
// reset is synchronous, active low, and clears the parser and both queue and output.
// o_stall rises only when the two-entry queue is full; with bytes arriving back to
// back, stalling the output while the output register holds fills it.
module mqtt_connect_payload_parser import mcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_section,
    output logic [7:0]  o_byte_out,
    output logic        o_is_content,
    output logic        o_username_present,
    output logic        o_password_present,
    output logic        o_lwt_retain,
    output logic [1:0]  o_lwt_qos,
    output logic        o_will_present,
    output logic        o_clean_start,
    output logic [15:0] o_alive_secs,
    output logic [7:0]  o_proto_rev,
    output logic [4:0]  o_status
);

    logic        w_in_fire;
    logic        w_pop;
    t_result     w_front_result;
    t_result     w_q_data;
    t_result     w_out;
    t_q_stat     w_q_stat;
    t_front_stat w_front_stat;

    assign o_stall   = w_q_stat.full;
    assign w_in_fire = i_valid && !w_q_stat.full;

    // section walk
    mcp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_in_fire),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_result    (w_front_result),
        .o_stat      (w_front_stat)
    );

    // decoupling queue
    mcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_in_fire),
        .i_data  (w_front_result),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_stat  (w_q_stat)
    );

    // output register
    mcp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (w_q_data),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (w_out)
    );

    // unpack result fields
    assign o_section          = w_out.section;
    assign o_byte_out         = w_out.byte_out;
    assign o_is_content       = w_out.is_content;
    assign o_username_present = w_out.flags[FLAG_USER];
    assign o_password_present = w_out.flags[FLAG_PW];
    assign o_lwt_retain       = w_out.flags[FLAG_RETAIN];
    assign o_lwt_qos          = w_out.flags[FLAG_QOS_HI:FLAG_QOS_LO];
    assign o_will_present     = w_out.flags[FLAG_WILL];
    assign o_clean_start      = w_out.flags[FLAG_CLEAN];
    assign o_alive_secs       = w_out.alive_secs;
    assign o_proto_rev        = w_out.proto_rev;
    assign o_status           = w_out.status;

`ifndef ASSERT_OFF
    // the last byte of a packet returns the parser to its start
    a_packet_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_last_byte) |=>
            (w_front_stat.section == SEC_NAME_LEN && !w_front_stat.high_seen))
        else $error("parser did not return to start after last byte");

    // the queue cannot be full and empty at once
    a_queue_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && !w_q_stat.not_empty))
        else $error("queue status inconsistent");

    // nothing is presented in the cycle after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // a free output register never leaves a queued transaction waiting
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_stat.not_empty && !o_valid) |-> w_pop)
        else $error("queued transaction not moved to empty output register");
`endif

endmodule

FILE: sim/tb.sv
// testbench for mqtt_connect_payload_parser: directed table, then random CONNECT bodies
// depends on mcp_pkg and the parser rtl; a behavioral predictor checks every result
`timescale 1ns / 100ps

module tb import mcp_pkg::*; ();

    localparam int ITEM_TARGET = 600;
    localparam int CYCLE_LIMIT = 200000;

    // one expected result transaction, field by field
    typedef struct packed {
        logic [3:0]  section;
        logic [7:0]  byte_out;
        logic        is_content;
        logic        user;
        logic        pw;
        logic        retain;
        logic [1:0]  qos;
        logic        will;
        logic        clean;
        logic [15:0] alive_secs;
        logic [7:0]  level;
        logic [4:0]  status;
    } t_expect;

    // directed stimulus row; section and status typed in where marked
    typedef struct {
        logic [7:0] d;
        logic       l;
        bit         typed;
        logic [3:0] sec;
        logic [4:0] st;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [3:0]  o_section;
    logic [7:0]  o_byte_out;
    logic        o_is_content;
    logic        o_username_present;
    logic        o_password_present;
    logic        o_lwt_retain;
    logic [1:0]  o_lwt_qos;
    logic        o_will_present;
    logic        o_clean_start;
    logic [15:0] o_alive_secs;
    logic [7:0]  o_proto_rev;
    logic [4:0]  o_status;

    mqtt_connect_payload_parser u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_section          (o_section),
        .o_byte_out         (o_byte_out),
        .o_is_content       (o_is_content),
        .o_username_present (o_username_present),
        .o_password_present (o_password_present),
        .o_lwt_retain       (o_lwt_retain),
        .o_lwt_qos          (o_lwt_qos),
        .o_will_present     (o_will_present),
        .o_clean_start      (o_clean_start),
        .o_alive_secs       (o_alive_secs),
        .o_proto_rev        (o_proto_rev),
        .o_status           (o_status)
    );

    always #5 i_clk = ~i_clk;

    // parser state mirrored by the predictor
    logic [3:0]  cur_sec  = SEC_NAME_LEN;
    logic        hi_seen  = 1'b0;
    logic [7:0]  len_hi   = 8'h00;
    logic [15:0] remain   = 16'h0000;
    logic [7:0]  flg      = 8'h00;
    logic [15:0] ka_q     = 16'h0000;
    logic [7:0]  lvl_q    = 8'h00;

    t_expect     pending_results[$];
    t_row        dir_rows[$];
    logic [7:0]  pkt[$];
    int          pkt_cap;
    int          errors = 0;
    int          n_items = 0;
    int          n_packets = 0;
    int          n_checked = 0;
    int          n_done = 0;
    int          n_trunc = 0;
    int          cycles = 0;
    int          hold_cnt = 0;
    bit          calm = 1'b0;

    // section entered when the string whose length section is given runs out
    function automatic logic [3:0] next_after(input logic [3:0] len_sec);
        logic [3:0] tail;
        logic [3:0] from_user;
        tail      = flg[FLAG_PW] ? SEC_PW_LEN : SEC_TRAILING;
        from_user = flg[FLAG_USER] ? SEC_USER_LEN : tail;
        if (len_sec == SEC_NAME_LEN)
            return SEC_LEVEL;
        if (len_sec == SEC_WTOPIC_LEN)
            return SEC_WMSG_LEN;
        if (len_sec == SEC_ID_LEN && flg[FLAG_WILL])
            return SEC_WTOPIC_LEN;
        if (len_sec == SEC_ID_LEN || len_sec == SEC_WMSG_LEN)
            return from_user;
        if (len_sec == SEC_USER_LEN)
            return tail;
        return SEC_TRAILING;
    endfunction

    // advance the mirrored parser by one byte and return the result it gives
    function automatic t_expect predict_byte(input logic [7:0] d, input logic l);
        t_expect     e;
        logic [3:0]  s;
        logic [15:0] len;
        logic        text;
        s    = cur_sec;
        len  = {len_hi, d};
        text = 1'b0;
        case (s)
            SEC_NAME_LEN, SEC_ID_LEN, SEC_WTOPIC_LEN,
            SEC_WMSG_LEN, SEC_USER_LEN, SEC_PW_LEN: begin
                if (!hi_seen) begin
                    hi_seen = 1'b1;
                    len_hi  = d;
                end else begin
                    hi_seen = 1'b0;
                    if (len == 16'h0000) begin
                        cur_sec = next_after(s);
                    end else begin
                        remain  = len;
                        cur_sec = s + 4'd1;
                    end
                end
            end
            SEC_NAME, SEC_ID, SEC_WTOPIC, SEC_WMSG, SEC_USER, SEC_PW: begin
                text = 1'b1;
                if (remain <= 16'd1) begin
                    remain  = 16'h0000;
                    cur_sec = next_after(s - 4'd1);
                end else begin
                    remain = remain - 16'd1;
                end
            end
            SEC_LEVEL: begin
                lvl_q   = d;
                cur_sec = SEC_FLAGS;
            end
            SEC_FLAGS: begin
                flg     = d;
                cur_sec = SEC_KEEPALIVE;
            end
            SEC_KEEPALIVE: begin
                if (!hi_seen) begin
                    hi_seen = 1'b1;
                    len_hi  = d;
                end else begin
                    hi_seen = 1'b0;
                    ka_q    = len;
                    cur_sec = SEC_ID_LEN;
                end
            end
            default: ;
        endcase
        e.section    = s;
        e.byte_out   = d;
        e.is_content = text;
        e.user       = flg[FLAG_USER];
        e.pw         = flg[FLAG_PW];
        e.retain     = flg[FLAG_RETAIN];
        e.qos        = flg[FLAG_QOS_HI:FLAG_QOS_LO];
        e.will       = flg[FLAG_WILL];
        e.clean      = flg[FLAG_CLEAN];
        e.alive_secs = ka_q;
        e.level      = lvl_q;
        e.status     = ST_BUSY;
        // end of packet: report and fall back to the reset state
        if (l) begin
            if (cur_sec == SEC_TRAILING) begin
                e.status = ST_DONE;
                n_done++;
            end else begin
                e.status = ST_TRUNC_BASE + {1'b0, cur_sec};
                n_trunc++;
            end
            cur_sec = SEC_NAME_LEN;
            hi_seen = 1'b0;
            len_hi  = 8'h00;
            remain  = 16'h0000;
            flg     = 8'h00;
            ka_q    = 16'h0000;
            lvl_q   = 8'h00;
        end
        return e;
    endfunction

    // idle cycles for one side; zero throughout a calm stretch
    function automatic int pause_len();
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic void add_row(input logic [7:0] d, input logic l = 1'b0,
                                    input bit typed = 1'b0,
                                    input logic [3:0] sec = SEC_NAME_LEN,
                                    input logic [4:0] st = ST_BUSY);
        t_row r;
        r.d     = d;
        r.l     = l;
        r.typed = typed;
        r.sec   = sec;
        r.st    = st;
        dir_rows.push_back(r);
    endfunction

    // packet bytes are dropped once the cut point is reached
    function automatic void put(input logic [7:0] b);
        if (pkt.size() < pkt_cap)
            pkt.push_back(b);
    endfunction

    function automatic int unsigned pick_len(input bit wide);
        int unsigned r;
        r = $urandom_range(0, 49);
        if (wide && $urandom_range(0, 2) == 0)
            return $urandom_range(0, 65535);
        if (r == 0)
            return $urandom_range(256, 300);
        if (r < 9)
            return 0;
        return $urandom_range(1, 5);
    endfunction

    function automatic void put_string(input bit wide);
        int unsigned len;
        len = pick_len(wide);
        put(len[15:8]);
        put(len[7:0]);
        for (int unsigned i = 0; i < len && pkt.size() < pkt_cap; i++)
            put(8'($urandom));
    endfunction

    // one well formed body, possibly cut short, with random content
    function automatic void build_body(input bit cut);
        logic [7:0]  f;
        logic [15:0] ka;
        bit          wide;
        int          k;
        pkt.delete();
        pkt_cap = cut ? $urandom_range(1, 30) : 32'h4000_0000;
        wide    = cut && $urandom_range(0, 1) == 1;
        f       = 8'($urandom);
        k       = $urandom_range(0, 3);
        ka      = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'($urandom);
        put_string(wide);
        put(($urandom_range(0, 3) == 0) ? 8'h04 : 8'($urandom));
        put(f);
        put(ka[15:8]);
        put(ka[7:0]);
        put_string(wide);
        if (f[FLAG_WILL]) begin
            put_string(wide);
            put_string(wide);
        end
        if (f[FLAG_USER])
            put_string(wide);
        if (f[FLAG_PW])
            put_string(wide);
        // occasional bytes past the last string
        if (!cut && $urandom_range(0, 3) == 0) begin
            k = $urandom_range(1, 3);
            repeat (k) put(8'($urandom));
        end
    endfunction

    // present one byte, wait for it to be taken, record what it should produce
    task automatic send_byte(input logic [7:0] d, input logic l, input bit typed,
                             input logic [3:0] tsec, input logic [4:0] tst);
        int      gap;
        t_expect e;
        if ($urandom_range(0, 99) == 0)
            calm = !calm;
        gap = pause_len();
        if (gap != 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_data_byte = d;
        i_last_byte = l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        e = predict_byte(d, l);
        if (typed) begin
            e.section = tsec;
            e.status  = tst;
        end
        pending_results.push_back(e);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
        end
    endtask

    // result side: compare each accepted transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_expect e;
        if (i_rst_n && o_valid && !i_stall) begin
            hold_cnt = pause_len();
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, section %0h byte %0h",
                         $time, o_section, o_byte_out);
            end else begin
                e = pending_results.pop_front();
                n_checked++;
                check_field("section", 16'(e.section), 16'(o_section));
                check_field("byte_out", 16'(e.byte_out), 16'(o_byte_out));
                check_field("is_content", 16'(e.is_content), 16'(o_is_content));
                check_field("username_present", 16'(e.user), 16'(o_username_present));
                check_field("password_present", 16'(e.pw), 16'(o_password_present));
                check_field("lwt_retain", 16'(e.retain), 16'(o_lwt_retain));
                check_field("lwt_qos", 16'(e.qos), 16'(o_lwt_qos));
                check_field("will_present", 16'(e.will), 16'(o_will_present));
                check_field("clean_start", 16'(e.clean), 16'(o_clean_start));
                check_field("alive_secs", e.alive_secs, o_alive_secs);
                check_field("proto_rev", 16'(e.level), 16'(o_proto_rev));
                check_field("status", 16'(e.status), 16'(o_status));
            end
        end
    end

    // result side stall after each transaction
    always @(negedge i_clk) begin
        if (hold_cnt != 0) begin
            i_stall = 1'b1;
            hold_cnt--;
        end else begin
            i_stall = 1'b0;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        int  kind;
        bit  noise;
        // short length cut off on its first byte
        add_row(8'hFF, 1'b1, 1'b1, SEC_NAME_LEN, ST_TRUNC_BASE + SEC_NAME_LEN);
        // every length section present, flags all ones, keep alive at its maximum
        add_row(8'h00); add_row(8'h01); add_row(8'h4D);
        add_row(8'h04); add_row(8'hFF); add_row(8'hFF); add_row(8'hFF);
        add_row(8'h00); add_row(8'h00);
        add_row(8'h00); add_row(8'h01); add_row(8'h61);
        add_row(8'h00); add_row(8'h00);
        add_row(8'h00); add_row(8'h00);
        add_row(8'h00); add_row(8'h01);
        add_row(8'h70, 1'b1, 1'b1, SEC_PW, ST_DONE);
        // all zero: empty name, no flags, ends on the client id length
        add_row(8'h00); add_row(8'h00); add_row(8'h00); add_row(8'h00);
        add_row(8'h00); add_row(8'h00); add_row(8'h00);
        add_row(8'h00, 1'b1, 1'b1, SEC_ID_LEN, ST_DONE);

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].d, dir_rows[i].l, dir_rows[i].typed,
                      dir_rows[i].sec, dir_rows[i].st);
        n_packets = 3;

        // random bodies: mostly whole, some cut short, some plain noise
        while (n_items < ITEM_TARGET) begin
            kind  = $urandom_range(0, 9);
            noise = (kind == 0);
            if (noise) begin
                pkt.delete();
                repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
            end else begin
                build_body(kind <= 2);
            end
            foreach (pkt[i])
                send_byte(pkt[i],
                          (i == pkt.size() - 1) || (noise && $urandom_range(0, 7) == 0),
                          1'b0, SEC_NAME_LEN, ST_BUSY);
            n_packets++;
        end
        i_valid     = 1'b0;
        i_last_byte = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("summary: %0d bytes in %0d bodies, %0d results checked",
                 n_items, n_packets, n_checked);
        $display("summary: %0d bodies complete, %0d cut short, %0d mismatches",
                 n_done, n_trunc, errors);
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
